### rtl/wdtkr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed watchdog timer package
// Shared types, register codes, keys and prescaler widths.
// ----------------------------------------------------------------------------
package wdtkr_pkg;

   // Prescaler base divisor is a power of two: 1 << BASE_LOG2.
   localparam int BASE_LOG2    = 5;
   localparam int BASE_DIVISOR = 1 << BASE_LOG2;

   // Clock select adds up to seven more bits to the prescaler period.
   localparam int CKS_W   = 3;
   localparam int CKS_MAX = (1 << CKS_W) - 1;

   // Remainder stays below BASE_DIVISOR << CKS_MAX.
   localparam int REM_W   = BASE_LOG2 + CKS_MAX;
   localparam int CYC_W   = 16;
   localparam int WIDE_W  = ((REM_W > CYC_W) ? REM_W : CYC_W) + 1;
   localparam int SHIFT_W = $clog2(BASE_LOG2 + CKS_MAX + 1);

   localparam int DATA_W = 16;
   localparam int BYTE_W = 8;

   // Write keys carried in the high byte of the write word.
   localparam logic [BYTE_W-1:0] KEY_CNT = 8'h5A;
   localparam logic [BYTE_W-1:0] KEY_CSR = 8'hA5;

   // Control/status bit positions.
   localparam int CS_TME  = 7;
   localparam int CS_WTIT = 6;
   localparam int CS_WOVF = 4;
   localparam int CS_IOVF = 3;

   // Register select codes.
   localparam logic SEL_COUNT = 1'b0;
   localparam logic SEL_CSR   = 1'b1;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic                reg_select;
      logic [DATA_W-1:0]   write_data;
      logic                full_width;
      logic [CYC_W-1:0]    cycles;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              write_taken;
      logic              interval_interrupt;
      logic              watchdog_overflow;
   } result_type;

endpackage

### rtl/wdtkr_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed watchdog timer execution unit
// Holds the counter, control/status and prescaler remainder, and works out
// the result of one registered item in a single combinational pass.
// ----------------------------------------------------------------------------
module wdtkr_exec (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  wdtkr_pkg::item_type   item,
   output wdtkr_pkg::result_type result
);

   logic [wdtkr_pkg::BYTE_W-1:0]  up_count_ff, up_count_in;
   logic [wdtkr_pkg::BYTE_W-1:0]  control_status_ff, control_status_in;
   logic [wdtkr_pkg::REM_W-1:0]   remainder_ff, remainder_in;

   logic [wdtkr_pkg::BYTE_W-1:0]  wr_key;
   logic [wdtkr_pkg::BYTE_W-1:0]  wr_val;
   logic [wdtkr_pkg::SHIFT_W-1:0] shift;
   logic [wdtkr_pkg::WIDE_W-1:0]  total;
   logic [wdtkr_pkg::WIDE_W-1:0]  periods;
   logic [wdtkr_pkg::WIDE_W-1:0]  rem_mask;
   logic [wdtkr_pkg::WIDE_W:0]    sum;
   logic                          wrap;

   // Prescaler arithmetic: the period is a power of two, so divide is a shift.
   assign wr_key   = item.write_data[wdtkr_pkg::DATA_W-1:wdtkr_pkg::BYTE_W];
   assign wr_val   = item.write_data[wdtkr_pkg::BYTE_W-1:0];
   assign shift    = wdtkr_pkg::SHIFT_W'(wdtkr_pkg::BASE_LOG2)
                   + wdtkr_pkg::SHIFT_W'(control_status_ff[wdtkr_pkg::CKS_W-1:0]);
   assign total    = wdtkr_pkg::WIDE_W'(remainder_ff) + wdtkr_pkg::WIDE_W'(item.cycles);
   assign periods  = total >> shift;
   assign rem_mask = ~({wdtkr_pkg::WIDE_W{1'b1}} << shift);
   assign sum      = {1'b0, periods} + (wdtkr_pkg::WIDE_W + 1)'(up_count_ff);
   assign wrap     = |sum[wdtkr_pkg::WIDE_W:wdtkr_pkg::BYTE_W];

   // Decode the item and form both the result and the next state.
   always_comb begin
      up_count_in       = up_count_ff;
      control_status_in = control_status_ff;
      remainder_in      = remainder_ff;
      result            = '0;
      unique case (item.kind)
         wdtkr_pkg::KIND_READ: begin
            result.read_data = (item.reg_select == wdtkr_pkg::SEL_CSR)
                             ? control_status_ff : up_count_ff;
         end
         wdtkr_pkg::KIND_WRITE: begin
            if (item.full_width) begin
               if (item.reg_select == wdtkr_pkg::SEL_COUNT) begin
                  if (wr_key == wdtkr_pkg::KEY_CNT) begin
                     up_count_in        = wr_val;
                     remainder_in       = '0;
                     result.write_taken = 1'b1;
                  end
               end else if (wr_key == wdtkr_pkg::KEY_CSR) begin
                  // A rising enable restarts the prescaler.
                  if (!control_status_ff[wdtkr_pkg::CS_TME] && wr_val[wdtkr_pkg::CS_TME]) begin
                     remainder_in = '0;
                  end
                  control_status_in  = wr_val;
                  result.write_taken = 1'b1;
               end
            end
         end
         wdtkr_pkg::KIND_TICK: begin
            if (control_status_ff[wdtkr_pkg::CS_TME]) begin
               remainder_in = wdtkr_pkg::REM_W'(total & rem_mask);
               up_count_in  = sum[wdtkr_pkg::BYTE_W-1:0];
               if (wrap) begin
                  if (control_status_ff[wdtkr_pkg::CS_WTIT]) begin
                     control_status_in[wdtkr_pkg::CS_WOVF] = 1'b1;
                     result.watchdog_overflow              = 1'b1;
                  end else begin
                     control_status_in[wdtkr_pkg::CS_IOVF] = 1'b1;
                     result.interval_interrupt             = 1'b1;
                  end
               end
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // Architectural state changes only when the item moves to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         up_count_ff       <= '0;
         control_status_ff <= '0;
         remainder_ff      <= '0;
      end else if (fire) begin
         up_count_ff       <= up_count_in;
         control_status_ff <= control_status_in;
         remainder_ff      <= remainder_in;
      end
   end

endmodule

### rtl/watchdog_timer_keyed_registers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed watchdog timer
// Each request passes through the input register, then the result register,
// before its response is valid; a response stall holds both registers.
// Throughput: one item per cycle unless rsp_stall holds the response. Reset
// clears the counter, control/status, prescaler remainder and valids.
// ----------------------------------------------------------------------------
module watchdog_timer_keyed_registers (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic        req_reg_select,
   input  logic [15:0] req_write_data,
   input  logic        req_full_width,
   input  logic [15:0] req_cycles,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_write_taken,
   output logic        rsp_interval_interrupt,
   output logic        rsp_watchdog_overflow
);

   logic                  in_valid_ff;
   wdtkr_pkg::item_type   in_item_ff;
   logic                  rsp_valid_ff;
   wdtkr_pkg::result_type rsp_result_ff;
   wdtkr_pkg::result_type exec_result;
   logic                  advance;
   logic                  take;

   // The result register loads when empty or when its transfer completes.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff.kind       <= wdtkr_pkg::kind_type'(req_kind);
         in_item_ff.reg_select <= req_reg_select;
         in_item_ff.write_data <= req_write_data;
         in_item_ff.full_width <= req_full_width;
         in_item_ff.cycles     <= req_cycles;
      end
   end

   // Timer state and single-pass item evaluation.
   wdtkr_exec u_exec (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (exec_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= exec_result;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_read_data          = rsp_result_ff.read_data;
   assign rsp_write_taken        = rsp_result_ff.write_taken;
   assign rsp_interval_interrupt = rsp_result_ff.interval_interrupt;
   assign rsp_watchdog_overflow  = rsp_result_ff.watchdog_overflow;

endmodule
